FILE: src/ssle_pkg.sv
package ssle_pkg;

	// List geometry
	localparam int DEPTH = 256;
	localparam int KEY_W = 20;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int LVL_N = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Stream widths, padded to whole bytes
	localparam int S_TDATA_W = ((KEY_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((KEY_W + 3 + 7) / 8) * 8;

	localparam logic [KEY_W-1:0] SENTINEL = {KEY_W{1'b1}};

	typedef enum logic [1:0] {
		REQ_PUSH   = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_SEARCH = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_EVAL
	} fsm_t;

	// Broadcast control shared by every cell of the row
	typedef struct packed {
		logic [KEY_W-1:0] cmp_key;  // key compared against each entry
		logic             cmp_en;   // capture compare flags
		logic [KEY_W-1:0] ins_key;  // key written at the insert point
		logic             shl;      // shift whole row toward the front
	} cell_ctl_t;

endpackage

FILE: src/ssle_cell.sv
module ssle_cell (
	input  logic                      clk,
	input  ssle_pkg::cell_ctl_t       ctl,
	input  logic                      valid,
	input  logic                      ins,
	input  logic                      shr,
	input  logic [ssle_pkg::KEY_W-1:0] left,
	input  logic [ssle_pkg::KEY_W-1:0] right,
	output logic [ssle_pkg::KEY_W-1:0] entry,
	output logic                      stop,
	output logic                      eq
);
	import ssle_pkg::*;

	logic [KEY_W-1:0] entry_q;
	logic             stop_s1;
	logic             eq_s1;

	// Hold, load the new key, or take a neighbor's entry
	always_ff @(posedge clk) begin
		if (ins) begin
			entry_q <= ctl.ins_key;
		end else if (shr) begin
			entry_q <= left;
		end else if (ctl.shl) begin
			entry_q <= right;
		end
	end

	// Flag the scan stop point and an exact hit against the incoming key
	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			stop_s1 <= !valid || (entry_q >= ctl.cmp_key);
			eq_s1   <= (entry_q == ctl.cmp_key);
		end
	end

	assign entry = entry_q;
	assign stop  = stop_s1;
	assign eq    = eq_s1;

endmodule

FILE: src/ssle_prefix.sv
module ssle_prefix (
	input  logic [ssle_pkg::DEPTH-1:0] stop,
	output logic [ssle_pkg::DEPTH-1:0] pre,
	output logic [ssle_pkg::DEPTH-1:0] first
);
	import ssle_pkg::*;

	logic [DEPTH-1:0] lvl [LVL_N+1];

	// Log-depth inclusive prefix OR over the stop flags
	always_comb begin
		lvl[0] = stop;
		for (int l = 0; l < LVL_N; l++) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (i >= (1 << l)) begin
					lvl[l+1][i] = lvl[l][i] | lvl[l][i - (1 << l)];
				end else begin
					lvl[l+1][i] = lvl[l][i];
				end
			end
		end
	end

	assign pre   = lvl[LVL_N];
	assign first = pre & ~(pre << 1);

endmodule

FILE: src/sorted_set_list_engine_core.sv
// Channel  | Direction | Payload
// ---------+-----------+-------------------------------------------------------
// s_*      | in        | tdata: key[19:0]; tuser: req_type[1:0]
// m_*      | out       | tdata: front_value[19:0], found[20], status[22:21]
//
// Per request, the accept edge captures compare flags in every cell of the list
// row; the commit edge resolves the scan point through a prefix network and
// shifts the row. A new request is taken only after the previous one commits.
// arst_n clears the count, control and output valid; entries are not cleared.
// A result waiting on m_tready holds the next commit: one more request is taken,
// then s_tready stays low until the waiting result transfers.
module sorted_set_list_engine_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ssle_pkg::S_TDATA_W-1:0]   s_tdata,   // key
	input  logic [1:0]                       s_tuser,   // req_type
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ssle_pkg::M_TDATA_W-1:0]   m_tdata    // front_value, found, status
);
	import ssle_pkg::*;

	fsm_t                  state_q, state_d;
	logic [CNT_W-1:0]      count_q;
	req_t                  req_q;
	logic [KEY_W-1:0]      key_q;
	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;

	logic                  accept;
	logic                  commit;
	logic                  out_free;
	cell_ctl_t             ctl;
	logic [DEPTH-1:0]      valid_vec;
	logic [DEPTH-1:0]      stop_vec;
	logic [DEPTH-1:0]      eq_vec;
	logic [DEPTH-1:0]      pre_vec;
	logic [DEPTH-1:0]      first_vec;
	logic [DEPTH-1:0]      ins_vec;
	logic [DEPTH-1:0]      shr_vec;
	logic [KEY_W-1:0]      ent [DEPTH];
	logic                  full;
	logic                  empty;
	logic                  match;
	logic                  do_ins;
	logic                  do_rem;
	logic [KEY_W-1:0]      front_d;
	logic                  found_d;
	status_t               status_d;

	assign out_free = !m_tvalid_q || m_tready;

	// Sequencer: take a request, then commit once the output slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = FSM_EVAL;
				end
			end
			FSM_EVAL: begin
				if (out_free) begin
					commit  = 1'b1;
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// Hold the request for the commit cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_t'(s_tuser);
			key_q <= s_tdata[KEY_W-1:0];
		end
	end

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// Scan result: first stop position and whether it holds the key; a sentinel key also matches past the tail
	always_comb begin
		logic hit_entry;
		logic at_tail;
		hit_entry = |(first_vec & valid_vec & eq_vec);
		at_tail   = !(|(first_vec & valid_vec));
		match     = hit_entry || (at_tail && (key_q == SENTINEL));
	end

	// Decide the row move and the result fields
	always_comb begin
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		ins_vec  = '0;
		shr_vec  = '0;
		front_d  = '0;
		found_d  = 1'b0;
		status_d = ST_OK;
		unique case (req_q)
			REQ_PUSH: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					do_ins  = commit;
					ins_vec = {{(DEPTH-1){1'b0}}, 1'b1};
					shr_vec = '1;
				end
			end
			REQ_INSERT: begin
				if (!match) begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						do_ins  = commit;
						ins_vec = first_vec;
						shr_vec = pre_vec;
					end
				end
			end
			REQ_REMOVE: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					do_rem  = commit;
					front_d = ent[0];
				end
			end
			REQ_SEARCH: begin
				found_d = match;
			end
			default: status_d = ST_OK;
		endcase
		if (!do_ins) begin
			ins_vec = '0;
			shr_vec = '0;
		end
	end

	assign ctl.cmp_key = s_tdata[KEY_W-1:0];
	assign ctl.cmp_en  = accept;
	assign ctl.ins_key = key_q;
	assign ctl.shl     = do_rem;

	// Row of list cells, front at index 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0] left_w;
		logic [KEY_W-1:0] right_w;

		assign valid_vec[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_w = key_q;
		end else begin : g_body_l
			assign left_w = ent[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_w = ent[i];
		end else begin : g_body_r
			assign right_w = ent[i+1];
		end

		ssle_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.valid (valid_vec[i]),
			.ins   (ins_vec[i]),
			.shr   (shr_vec[i]),
			.left  (left_w),
			.right (right_w),
			.entry (ent[i]),
			.stop  (stop_vec[i]),
			.eq    (eq_vec[i])
		);
	end

	ssle_prefix u_prefix (
		.stop  (stop_vec),
		.pre   (pre_vec),
		.first (first_vec)
	);

	// Track the number of valid entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_ins) begin
			count_q <= count_q + 1'b1;
		end else if (do_rem) begin
			count_q <= count_q - 1'b1;
		end
	end

	// Output register: load on commit, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_tdata_q <= M_TDATA_W'({status_d, found_d, front_d});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: sim/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ssle_pkg::*;

	localparam int ITEMS_RND      = 900;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 12;

	typedef struct packed {
		logic [KEY_W-1:0] front;
		logic             found;
		status_t          status;
	} list_result_t;

	typedef struct {
		req_t             req;
		logic [KEY_W-1:0] key;
		bit               typed;
		list_result_t     want;
	} stim_row_t;

	typedef enum {
		MODE_FILL,
		MODE_FULL,
		MODE_DRAIN,
		MODE_EMPTY,
		MODE_MIX
	} gen_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;    // key
	logic [1:0]           s_tuser;    // req_type
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;    // front_value, found, status

	// Shadow copy of the list contents
	logic [KEY_W-1:0] shadow_keys [DEPTH];
	int               shadow_cnt;

	list_result_t pending_results [$];
	stim_row_t    stim_rows [$];
	int           err_cnt;
	int           snd_idle_pct;
	int           rcv_idle_pct;
	bit           hold_req;
	int           quiet_cycles;

	sorted_set_list_engine_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		err_cnt++;
	endtask

	// Apply one request to the shadow list and return its result
	function automatic list_result_t list_apply(req_t req, logic [KEY_W-1:0] k);
		list_result_t r;
		int           p;
		int           i;
		bit           hit;
		r = '{front: '0, found: 1'b0, status: ST_OK};
		p = 0;
		if (req == REQ_INSERT || req == REQ_SEARCH) begin
			while (p < shadow_cnt && shadow_keys[p] < k)
				p++;
		end
		hit = (p < shadow_cnt) ? (shadow_keys[p] == k) : (k == SENTINEL);
		case (req) inside
			REQ_PUSH, REQ_INSERT: begin
				if (req == REQ_INSERT && hit) begin
					// duplicate or sentinel: nothing stored
				end else if (shadow_cnt >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (i = shadow_cnt; i > p; i--)
						shadow_keys[i] = shadow_keys[i-1];
					shadow_keys[p] = k;
					shadow_cnt++;
				end
			end
			REQ_REMOVE: begin
				if (shadow_cnt == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.front = shadow_keys[0];
					for (i = 0; i < shadow_cnt - 1; i++)
						shadow_keys[i] = shadow_keys[i+1];
					shadow_cnt--;
				end
			end
			default: r.found = hit;
		endcase
		return r;
	endfunction

	function automatic void add_row(req_t req, logic [KEY_W-1:0] key, bit typed,
			logic [KEY_W-1:0] front = '0, logic found = 1'b0, status_t st = ST_OK);
		stim_row_t row;
		row.req   = req;
		row.key   = key;
		row.typed = typed;
		row.want  = '{front: front, found: found, status: st};
		stim_rows = {stim_rows, row};
	endfunction

	// Mix of list members, small values, extremes and random keys
	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30 && shadow_cnt > 0)
			return shadow_keys[$urandom_range(0, shadow_cnt - 1)];
		if (r < 45)
			return KEY_W'($urandom_range(0, 15));
		if (r < 50)
			return SENTINEL;
		if (r < 55)
			return '0;
		if (r < 60)
			return SENTINEL - 1'b1;
		return KEY_W'($urandom);
	endfunction

	function automatic req_t pick_req(gen_mode_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			MODE_FILL:  return (r < 40) ? REQ_INSERT : (r < 75) ? REQ_PUSH :
					(r < 90) ? REQ_SEARCH : REQ_REMOVE;
			MODE_FULL:  return (r < 40) ? REQ_INSERT : (r < 70) ? REQ_PUSH : REQ_SEARCH;
			MODE_DRAIN: return (r < 80) ? REQ_REMOVE : (r < 90) ? REQ_SEARCH : REQ_INSERT;
			MODE_EMPTY: return (r < 60) ? REQ_REMOVE : REQ_SEARCH;
			default:    return req_t'(r % 4);
		endcase
	endfunction

	// Offer one request, wait for its transfer, record what it should return
	task automatic send_req(req_t req, logic [KEY_W-1:0] key, bit typed, list_result_t want);
		list_result_t pred;
		if ($urandom_range(0, 99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'(key);
		s_tuser  <= req;
		do @(posedge clk); while (!s_tready);
		pred = list_apply(req, key);
		if (typed)
			pred = want;
		pending_results = {pending_results, pred};
	endtask

	// Drop valid and wait until every result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[KEY_W-1:0] !== want.front)
					report_mismatch("front_value", m_tdata[KEY_W-1:0], want.front);
				if (m_tdata[KEY_W] !== want.found)
					report_mismatch("found", m_tdata[KEY_W], want.found);
				if (m_tdata[KEY_W+2:KEY_W+1] !== want.status)
					report_mismatch("status", m_tdata[KEY_W+2:KEY_W+1], want.status);
			end
		end
	end

	// Abort when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		gen_mode_t    mode;
		int           mode_items;
		int           n;
		req_t         req;
		list_result_t none;

		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		err_cnt      = 0;
		hold_req     = 1'b0;
		quiet_cycles = 0;
		shadow_cnt   = 0;
		snd_idle_pct = 10;
		rcv_idle_pct = 79;
		none         = '0;

		// Directed rows: empty list, sentinel, duplicates, unsorted contents
		add_row(REQ_REMOVE, '0, 1'b1, '0, 1'b0, ST_EMPTY);
		add_row(REQ_SEARCH, SENTINEL, 1'b1, '0, 1'b1, ST_OK);
		add_row(REQ_SEARCH, '0, 1'b1);
		add_row(REQ_INSERT, SENTINEL, 1'b1);
		add_row(REQ_REMOVE, SENTINEL, 1'b1, '0, 1'b0, ST_EMPTY);
		add_row(REQ_INSERT, 20'h00005, 1'b1);
		add_row(REQ_INSERT, 20'h00005, 1'b1);
		add_row(REQ_INSERT, '0, 1'b1);
		add_row(REQ_INSERT, SENTINEL - 1'b1, 1'b1);
		add_row(REQ_INSERT, 20'hAAAAA, 1'b0);
		add_row(REQ_INSERT, 20'h55555, 1'b0);
		add_row(REQ_PUSH, SENTINEL, 1'b0);
		add_row(REQ_PUSH, 20'h00003, 1'b0);
		add_row(REQ_SEARCH, 20'h00005, 1'b0);
		add_row(REQ_INSERT, 20'h00004, 1'b0);
		add_row(REQ_SEARCH, SENTINEL, 1'b1, '0, 1'b1, ST_OK);
		add_row(REQ_SEARCH, 20'hAAAAA, 1'b0);
		add_row(REQ_REMOVE, '0, 1'b0);
		add_row(REQ_REMOVE, 20'h55555, 1'b0);
		add_row(REQ_REMOVE, 20'hAAAAA, 1'b0);
		add_row(REQ_SEARCH, 20'h55555, 1'b0);
		add_row(REQ_PUSH, '0, 1'b0);
		add_row(REQ_REMOVE, '0, 1'b0);
		add_row(REQ_SEARCH, 20'h00004, 1'b0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			send_req(stim_rows[i].req, stim_rows[i].key, stim_rows[i].typed, stim_rows[i].want);

		// Random part: grow to full, sit at full, drain past empty, then mix, and repeat
		mode       = MODE_FILL;
		mode_items = 0;
		for (n = 0; n < ITEMS_RND; n++) begin
			if (n == ITEMS_RND / 3) begin
				drain_results();
				snd_idle_pct = 79;
				rcv_idle_pct = 10;
			end else if (n == 2 * ITEMS_RND / 3) begin
				drain_results();
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			if (n == ITEMS_RND / 3 + 50 || n == 2 * ITEMS_RND / 3 + 80)
				hold_req = 1'b1;

			req = pick_req(mode);
			send_req(req, pick_key(), 1'b0, none);
			mode_items++;

			// Advance the generator mode from the shadow fill level or the items sent in the mode
			case (mode)
				MODE_FILL:  if (shadow_cnt == DEPTH) begin
					mode = MODE_FULL;
					mode_items = 0;
				end
				MODE_FULL:  if (mode_items >= 30) begin
					mode = MODE_DRAIN;
					mode_items = 0;
				end
				MODE_DRAIN: if (shadow_cnt == 0) begin
					mode = MODE_EMPTY;
					mode_items = 0;
				end
				MODE_EMPTY: if (mode_items >= 8) begin
					mode = MODE_MIX;
					mode_items = 0;
				end
				default:    if (mode_items >= 80) begin
					mode = MODE_FILL;
					mode_items = 0;
				end
			endcase
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never returned", 0, pending_results.size());

		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: sim.f
src/ssle_pkg.sv
src/ssle_cell.sv
src/ssle_prefix.sv
src/sorted_set_list_engine_core.sv
sim/tb_top.sv
